FILE: hw/rtl/tmlc_pkg.sv
// Shared types, constants and helper functions of the tiny MLP classifier.
`default_nettype none

package tmlc_pkg;

	// Command codes of the input channel.
	localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
	localparam logic [1:0] CMD_LOAD_TABLE  = 2'd1;
	localparam logic [1:0] CMD_CLASSIFY    = 2'd2;

	// Result kinds of the output channel.
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_WORD = 1'b1;

	// Default network shape.
	localparam int DEF_NUM_FEATURES = 7;
	localparam int DEF_NUM_HIDDEN   = 2;
	localparam int DEF_HIDDEN_SHIFT = 5;

	// Fixed sizes of the interface and the activation table.
	localparam int FEATURE_FIELDS = 7;
	localparam int TABLE_DEPTH    = 256;
	localparam int TABLE_AW       = 8;
	localparam int WORD_W         = 25;
	localparam int PROD_W         = 17;

	// Store write broadcast to the lanes and the merge stage.
	typedef struct packed {
		logic       weight_we;
		logic       table_we;
		logic [7:0] index;
		logic [7:0] value;
	} load_t;

	// Hand-off from the front end to the merge stage.
	typedef struct packed {
		logic merge;
		logic ack;
		logic last;
	} issue_t;

	// A bias weight scaled by 255, done as a shift and a subtract.
	function automatic logic signed [PROD_W-1:0] mul255(input logic signed [7:0] w);
		logic signed [PROD_W-1:0] x;
		x = PROD_W'(w);
		return (x <<< 8) - x;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tmlc_lane.sv
// One hidden unit: weights, multiply, sum, activation table and output product.
`default_nettype none

module tmlc_lane #(
	parameter int NUM_FEATURES = tmlc_pkg::DEF_NUM_FEATURES,
	parameter int NUM_HIDDEN   = tmlc_pkg::DEF_NUM_HIDDEN,
	parameter int HIDDEN_SHIFT = tmlc_pkg::DEF_HIDDEN_SHIFT,
	parameter int LANE         = 0
) (
	input  wire logic                                clk,
	input  wire tmlc_pkg::load_t                     load,
	input  wire logic [NUM_FEATURES-1:0][7:0]        feat,
	output logic signed [tmlc_pkg::PROD_W-1:0]       oprod_s4
);
	import tmlc_pkg::*;

	localparam int HID_COUNT = (NUM_FEATURES + 1) * NUM_HIDDEN;
	localparam int ACC_W     = PROD_W + $clog2(NUM_FEATURES + 1);
	localparam int T_W       = ACC_W + 1;

	logic signed [7:0]        hw_q [NUM_FEATURES+1];
	logic signed [7:0]        ow_q;
	logic [7:0]               tab_mem [TABLE_DEPTH];

	logic signed [PROD_W-1:0] bias_s1;
	logic signed [PROD_W-1:0] prod_s1 [NUM_FEATURES];
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  sum_s2;
	logic signed [T_W-1:0]    t;
	logic [TABLE_AW-1:0]      addr;
	logic [7:0]               tab_s3;

	// Weight registers of this unit; row 0 is the bias.
	always_ff @(posedge clk) begin
		for (int r = 0; r <= NUM_FEATURES; r++) begin
			if (load.weight_we && load.index == 8'(r * NUM_HIDDEN + LANE)) begin
				hw_q[r] <= load.value;
			end
		end
		if (load.weight_we && load.index == 8'(HID_COUNT + 1 + LANE)) begin
			ow_q <= load.value;
		end
	end

	// Products of the features with this unit's weights.
	always_ff @(posedge clk) begin
		bias_s1 <= mul255(hw_q[0]);
		for (int i = 0; i < NUM_FEATURES; i++) begin
			prod_s1[i] <= $signed({1'b0, feat[i]}) * hw_q[i+1];
		end
	end

	always_comb begin
		sum = ACC_W'(bias_s1);
		for (int i = 0; i < NUM_FEATURES; i++) begin
			sum = sum + ACC_W'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum;
	end

	// Floor shift, re-center on 128 and clamp into the table range.
	always_comb begin
		t = $signed({sum_s2[ACC_W-1], sum_s2 >>> HIDDEN_SHIFT}) + $signed(T_W'(128));
		if (t < 0) begin
			addr = '0;
		end else if (t > $signed(T_W'(255))) begin
			addr = '1;
		end else begin
			addr = t[TABLE_AW-1:0];
		end
	end

	// Private copy of the activation table, written by every table load.
	always_ff @(posedge clk) begin
		if (load.table_we) begin
			tab_mem[load.index] <= load.value;
		end
		tab_s3 <= tab_mem[addr];
	end

	always_ff @(posedge clk) begin
		oprod_s4 <= $signed({1'b0, tab_s3}) * ow_q;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tmlc_pack.sv
// Output unit merge, threshold, four-lane packing and output register.
`default_nettype none

module tmlc_pack #(
	parameter int NUM_FEATURES = tmlc_pkg::DEF_NUM_FEATURES,
	parameter int NUM_HIDDEN   = tmlc_pkg::DEF_NUM_HIDDEN
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tmlc_pkg::load_t                      load,
	input  wire tmlc_pkg::issue_t                     issue,
	input  wire logic signed [tmlc_pkg::PROD_W-1:0]   oprod [NUM_HIDDEN],
	output logic                                      busy,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      result_kind,
	output logic [tmlc_pkg::WORD_W-1:0]               packed_word,
	output logic                                      last_word
);
	import tmlc_pkg::*;

	localparam int HID_COUNT = (NUM_FEATURES + 1) * NUM_HIDDEN;
	localparam int OUT_W     = PROD_W + $clog2(NUM_HIDDEN + 1);

	logic signed [7:0]       ob_q;
	logic signed [OUT_W-1:0] sum;
	logic                    y;
	logic                    v_s5;
	logic                    ack_s5;
	logic                    y_s5;
	logic                    last_s5;
	logic [2:0]              pend_q;
	logic [1:0]              slot_q;
	logic [3:0]              lanes;
	logic [WORD_W-1:0]       word;
	logic                    go;
	logic                    emit;
	logic                    out_valid_q;
	logic                    result_kind_q;
	logic [WORD_W-1:0]       packed_word_q;
	logic                    last_word_q;

	always_ff @(posedge clk) begin
		if (load.weight_we && load.index == 8'(HID_COUNT)) begin
			ob_q <= load.value;
		end
	end

	always_comb begin
		sum = OUT_W'(mul255(ob_q));
		for (int n = 0; n < NUM_HIDDEN; n++) begin
			sum = sum + OUT_W'(oprod[n]);
		end
		y = sum > 0;
	end

	// Pending lanes are filled in order, so bits above the slot are zero.
	always_comb begin
		lanes = {1'b0, pend_q} | (4'(y_s5) << slot_q);
		word  = '0;
		for (int k = 0; k < 4; k++) begin
			word[8*k] = lanes[k];
		end
	end

	assign go   = v_s5 && (!out_valid_q || out_ready);
	assign emit = ack_s5 || slot_q == 2'd3 || last_s5;
	assign busy = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= '0;
			slot_q      <= '0;
		end else begin
			if (issue.ack || issue.merge) begin
				v_s5 <= 1'b1;
			end else if (go) begin
				v_s5 <= 1'b0;
			end
			if (go && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go && !ack_s5) begin
				if (emit) begin
					pend_q <= '0;
					slot_q <= '0;
				end else begin
					pend_q <= lanes[2:0];
					slot_q <= slot_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue.ack || issue.merge) begin
			ack_s5  <= issue.ack;
			y_s5    <= y;
			last_s5 <= issue.last;
		end
		if (go) begin
			if (ack_s5) begin
				result_kind_q <= KIND_ACK;
				packed_word_q <= WORD_W'(1);
				last_word_q   <= 1'b1;
			end else begin
				result_kind_q <= KIND_WORD;
				packed_word_q <= word;
				last_word_q   <= last_s5;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign packed_word = packed_word_q;
	assign last_word   = last_word_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tiny_mlp_lut_sigmoid_classifier_core.sv
// Top level of the tiny MLP classifier with table-based sigmoid activation.
`default_nettype none

// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------------
// input     in_valid / in_ready   command, entry_index, entry_value,
//                                 feature_0 .. feature_6, is_last
// output    out_valid / out_ready result_kind, packed_word, last_word
//
// One classify item is in flight at a time and passes through six registered
// steps: feature products, hidden sum, table read, output product, merge, and
// the output register. After a classify item, a new item is taken once that
// item has left the merge register, which needs a free output register. A
// load that carries is_last returns an acknowledge through the merge
// register; other loads leave the input open. in_ready is low while any item
// is in the pipeline or the merge register. A result waiting in the output
// register does not close the input, but the next result then waits in the
// merge register, and the input stays closed until the output register is
// taken. Reset clears the pipeline valids, the packing state and the output
// valid; the weight and table stores hold whatever they held until loaded.

module tiny_mlp_lut_sigmoid_classifier_core #(
	parameter int NUM_FEATURES = tmlc_pkg::DEF_NUM_FEATURES,
	parameter int NUM_HIDDEN   = tmlc_pkg::DEF_NUM_HIDDEN,
	parameter int HIDDEN_SHIFT = tmlc_pkg::DEF_HIDDEN_SHIFT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     command,
	input  wire logic [7:0]                     entry_index,
	input  wire logic signed [8:0]              entry_value,
	input  wire logic [7:0]                     feature_0,
	input  wire logic [7:0]                     feature_1,
	input  wire logic [7:0]                     feature_2,
	input  wire logic [7:0]                     feature_3,
	input  wire logic [7:0]                     feature_4,
	input  wire logic [7:0]                     feature_5,
	input  wire logic [7:0]                     feature_6,
	input  wire logic                           is_last,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                result_kind,
	output logic [tmlc_pkg::WORD_W-1:0]         packed_word,
	output logic                                last_word
);
	import tmlc_pkg::*;

	logic [FEATURE_FIELDS-1:0][7:0] field;
	logic [NUM_FEATURES-1:0][7:0]   feat;
	logic                           accept;
	logic                           is_load;
	load_t                          load;
	issue_t                         issue;
	logic                           v_s1;
	logic                           v_s2;
	logic                           v_s3;
	logic                           v_s4;
	logic                           last_q;
	logic                           merge_busy;
	logic signed [PROD_W-1:0]       oprod [NUM_HIDDEN];

	assign field = {feature_6, feature_5, feature_4, feature_3,
	                feature_2, feature_1, feature_0};

	// A network wider than the feature fields sees zero on the extra inputs.
	for (genvar i = 0; i < NUM_FEATURES; i++) begin : g_feat
		if (i < FEATURE_FIELDS) begin : g_field
			assign feat[i] = field[i];
		end else begin : g_zero
			assign feat[i] = '0;
		end
	end

	// Only one item is in flight, so the input opens once the pipe is empty.
	assign in_ready = !(v_s1 || v_s2 || v_s3 || v_s4 || merge_busy);
	assign accept   = in_valid && in_ready;
	assign is_load  = command == CMD_LOAD_WEIGHT || command == CMD_LOAD_TABLE;

	// Stores are written at the accepting edge; no classify item is in flight
	// then, so no read ever races a write.
	assign load.weight_we = accept && command == CMD_LOAD_WEIGHT;
	assign load.table_we  = accept && command == CMD_LOAD_TABLE;
	assign load.index     = entry_index;
	assign load.value     = entry_value[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept && command == CMD_CLASSIFY;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// The batch mark rides alongside the single item in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= is_last;
		end
	end

	assign issue.merge = v_s4;
	assign issue.ack   = accept && is_load && is_last;
	assign issue.last  = last_q;

	// One lane per hidden unit, each with its own weights and table copy.
	for (genvar n = 0; n < NUM_HIDDEN; n++) begin : g_lane
		tmlc_lane #(
			.NUM_FEATURES (NUM_FEATURES),
			.NUM_HIDDEN   (NUM_HIDDEN),
			.HIDDEN_SHIFT (HIDDEN_SHIFT),
			.LANE         (n)
		) u_lane (
			.clk      (clk),
			.load     (load),
			.feat     (feat),
			.oprod_s4 (oprod[n])
		);
	end

	// The merge stage sums the lanes, thresholds and packs the result.
	tmlc_pack #(
		.NUM_FEATURES (NUM_FEATURES),
		.NUM_HIDDEN   (NUM_HIDDEN)
	) u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.issue       (issue),
		.oprod       (oprod),
		.busy        (merge_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.packed_word (packed_word),
		.last_word   (last_word)
	);

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the tiny MLP classifier core with a predicting scoreboard.
`timescale 1ns / 1ps

module testbench;
	import tmlc_pkg::*;

	// Shape of the network as built with the default parameters.
	localparam int NF          = DEF_NUM_FEATURES;
	localparam int NH          = DEF_NUM_HIDDEN;
	localparam int HS          = DEF_HIDDEN_SHIFT;
	localparam int HID_ENTRIES = (NF + 1) * NH;
	localparam int OUT_ENTRIES = NH + 1;
	localparam int ALL_WEIGHTS = HID_ENTRIES + OUT_ENTRIES;

	// The fourth command code, which the block must ignore.
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam int SAMPLE_W     = FEATURE_FIELDS * 8;
	localparam int PHASE_ITEMS  = 190;
	localparam int PHASES       = 6;
	localparam int LONG_HOLD    = 400;
	localparam int BURST_ITEMS  = 40;
	localparam int TAIL_CYCLES  = 30;
	localparam int TIMEOUT_NS   = 20_000_000;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] word;
		logic              last;
	} expected_t;

	// Mirrors the stores and the lane packing of the block and keeps the
	// results that accepted items are due to produce, oldest first.
	class classify_scoreboard;
		logic signed [7:0] hidden_w [HID_ENTRIES];
		logic signed [7:0] output_w [OUT_ENTRIES];
		logic [7:0]        sig_lut [TABLE_DEPTH];
		logic [2:0]        held_bits;
		logic [1:0]        next_lane;
		expected_t         expected_q [$];
		int                mismatches;
		int                words_checked;
		int                acks_checked;

		function new();
			held_bits = '0;
			next_lane = '0;
			mismatches = 0;
			words_checked = 0;
			acks_checked = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		// One bit of classification: two sigmoid units, then a linear sum.
		function logic decide_sample(logic [SAMPLE_W-1:0] sample);
			int acc_out;
			int acc;
			int t;
			acc_out = int'(output_w[0]) * 255;
			for (int n = 0; n < NH; n++) begin
				acc = int'(hidden_w[n]) * 255;
				for (int i = 0; i < NF; i++)
					acc += int'(sample[8*i +: 8]) * int'(hidden_w[(i + 1) * NH + n]);
				t = (acc >>> HS) + 128;
				if (t < 0)
					t = 0;
				if (t > 255)
					t = 255;
				acc_out += int'(sig_lut[t[7:0]]) * int'(output_w[n + 1]);
			end
			return acc_out > 0;
		endfunction

		function void note_item(logic [1:0] cmd, logic [7:0] idx, logic signed [8:0] val,
				logic [SAMPLE_W-1:0] sample, logic last);
			expected_t  want;
			logic       y;
			want.kind = KIND_ACK;
			want.word = WORD_W'(1);
			want.last = 1'b1;
			case (cmd)
				CMD_LOAD_WEIGHT: begin
					if (idx < HID_ENTRIES)
						hidden_w[idx] = val[7:0];
					else if (idx < ALL_WEIGHTS)
						output_w[idx - HID_ENTRIES] = val[7:0];
					if (last)
						expected_q.push_back(want);
				end
				CMD_LOAD_TABLE: begin
					sig_lut[idx] = val[7:0];
					if (last)
						expected_q.push_back(want);
				end
				CMD_CLASSIFY: begin
					y = decide_sample(sample);
					if (next_lane == 2'd3 || last) begin
						want.kind = KIND_WORD;
						want.word = '0;
						for (int k = 0; k < 3; k++)
							if (k < next_lane)
								want.word[8*k] = held_bits[k];
						want.word[8*next_lane] = y;
						want.last = last;
						expected_q.push_back(want);
						held_bits = '0;
						next_lane = '0;
					end else begin
						held_bits[next_lane] = y;
						next_lane = next_lane + 2'd1;
					end
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_result(logic kind, logic [WORD_W-1:0] word, logic last);
			expected_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing expected (kind %b word %h last %b)",
					kind, word, last));
				return;
			end
			want = expected_q.pop_front();
			if (kind !== want.kind)
				report($sformatf("result_kind %b, expected %b", kind, want.kind));
			if (word !== want.word)
				report($sformatf("packed_word %h, expected %h", word, want.word));
			if (last !== want.last)
				report($sformatf("last_word %b, expected %b", last, want.last));
			if (want.kind == KIND_ACK)
				acks_checked++;
			else
				words_checked++;
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          command;
	logic [7:0]          entry_index;
	logic signed [8:0]   entry_value;
	logic [7:0]          feature [FEATURE_FIELDS];
	logic                is_last;
	logic                out_valid;
	logic                out_ready;
	logic                result_kind;
	logic [WORD_W-1:0]   packed_word;
	logic                last_word;

	classify_scoreboard board = new();

	// Knobs shared by the sender and the receiver. When a side is calm it
	// never idles; hold_requests asks the receiver for one long hold-off.
	bit send_calm;
	bit recv_calm;
	int hold_requests;

	// Totals for the closing summary.
	int samples_sent;
	int loads_sent;
	int ignored_sent;
	int counted_items;

	tiny_mlp_lut_sigmoid_classifier_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.feature_0   (feature[0]),
		.feature_1   (feature[1]),
		.feature_2   (feature[2]),
		.feature_3   (feature[3]),
		.feature_4   (feature[4]),
		.feature_5   (feature[5]),
		.feature_6   (feature[6]),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.packed_word (packed_word),
		.last_word   (last_word)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Features lean on the ends of their range one time in four.
	function automatic logic [SAMPLE_W-1:0] random_sample();
		logic [SAMPLE_W-1:0] s;
		for (int i = 0; i < FEATURE_FIELDS; i++)
			case ($urandom_range(0, 7))
				0: s[8*i +: 8] = 8'h00;
				1: s[8*i +: 8] = 8'hFF;
				default: s[8*i +: 8] = 8'($urandom_range(0, 255));
			endcase
		return s;
	endfunction

	// Small weights keep the hidden sums out of the clamps; the full range
	// of the field exercises the clamps and the sign of the low byte.
	function automatic int random_weight();
		if ($urandom_range(0, 1) == 0)
			return int'($urandom_range(0, 12)) - 6;
		return int'($urandom_range(0, 383)) - 128;
	endfunction

	// Offers one item after an optional gap and returns at the clock edge
	// where it was taken. The scoreboard learns of it only at that edge.
	task automatic offer_item(logic [1:0] cmd, int idx, int val,
			logic [SAMPLE_W-1:0] sample, bit last);
		int gap;
		gap = send_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		entry_index <= 8'(idx);
		entry_value <= 9'(val);
		for (int i = 0; i < FEATURE_FIELDS; i++)
			feature[i] <= sample[8*i +: 8];
		is_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_item(cmd, 8'(idx), 9'(val), sample, last);
		if (cmd == CMD_CLASSIFY)
			samples_sent++;
		else if (cmd == CMD_NONE)
			ignored_sent++;
		else
			loads_sent++;
		// Commands the block skips, and weight loads past the last entry
		// that ask for nothing back, are not part of the item budget.
		if (cmd != CMD_NONE && !(cmd == CMD_LOAD_WEIGHT && idx >= ALL_WEIGHTS && !last))
			counted_items++;
	endtask

	// Drops valid and waits until every predicted result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	// Random traffic: mostly samples, with loads into both stores, some of
	// them past the weight store, and a few items of the unused command.
	task automatic offer_random_item();
		int pick;
		int idx;
		pick = $urandom_range(0, 99);
		if (pick < 68) begin
			offer_item(CMD_CLASSIFY, $urandom_range(0, 255), int'($urandom_range(0, 511)) - 256,
				random_sample(), $urandom_range(0, 9) == 0);
		end else if (pick < 80) begin
			idx = ($urandom_range(0, 6) == 0) ? $urandom_range(ALL_WEIGHTS, 255)
				: $urandom_range(0, ALL_WEIGHTS - 1);
			offer_item(CMD_LOAD_WEIGHT, idx, random_weight(), random_sample(),
				$urandom_range(0, 7) == 0);
		end else if (pick < 95) begin
			offer_item(CMD_LOAD_TABLE, $urandom_range(0, 255), int'($urandom_range(0, 383)) - 128,
				random_sample(), $urandom_range(0, 7) == 0);
		end else begin
			offer_item(CMD_NONE, $urandom_range(0, 255), int'($urandom_range(0, 511)) - 256,
				random_sample(), $urandom_range(0, 1) == 1);
		end
	endtask

	// Receiver. Every result taken is checked against the oldest prediction.
	// Outside calm stretches it stalls at random; on request it holds off
	// for a long stretch so that results back up into the block and the
	// input side has to stop.
	initial begin
		int stall_left;
		int hold_left;
		int holds_done;
		stall_left = 0;
		hold_left = 0;
		holds_done = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_result(result_kind, packed_word, last_word);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!recv_calm && $urandom_range(0, 4) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Stimulus. The stores are filled completely before the first sample so
	// that no sample ever reads an entry that was never written. A short
	// directed run then covers the corners, and random phases follow.
	initial begin
		logic [SAMPLE_W-1:0] zeros;
		logic [SAMPLE_W-1:0] ones;
		logic [SAMPLE_W-1:0] stripes;
		int                  phase_end;
		zeros = '0;
		ones = '1;
		stripes = {{4{8'h55}}, {3{8'hAA}}};
		send_calm = 1'b1;
		recv_calm = 1'b1;
		hold_requests = 0;
		samples_sent = 0;
		loads_sent = 0;
		ignored_sent = 0;
		counted_items = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_NONE;
		entry_index <= '0;
		entry_value <= '0;
		for (int i = 0; i < FEATURE_FIELDS; i++)
			feature[i] <= '0;
		is_last <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Small weights everywhere and an identity activation table; the
		// final table load carries is_last and is acknowledged.
		for (int i = 0; i < ALL_WEIGHTS; i++)
			offer_item(CMD_LOAD_WEIGHT, i, int'($urandom_range(0, 12)) - 6, random_sample(), 1'b0);
		for (int i = 0; i < TABLE_DEPTH; i++)
			offer_item(CMD_LOAD_TABLE, i, i, random_sample(), i == TABLE_DEPTH - 1);

		// Lanes fill in order; loads past the weight store and the unused
		// command in between must not disturb the word being built.
		offer_item(CMD_CLASSIFY, 0, 0, zeros, 1'b0);
		offer_item(CMD_CLASSIFY, 255, -128, ones, 1'b0);
		offer_item(CMD_LOAD_WEIGHT, ALL_WEIGHTS, 127, stripes, 1'b0);
		offer_item(CMD_LOAD_WEIGHT, 255, -128, zeros, 1'b0);
		offer_item(CMD_NONE, 255, 255, ones, 1'b1);
		offer_item(CMD_CLASSIFY, 0, 0, stripes, 1'b0);
		offer_item(CMD_CLASSIFY, 0, 0, ones, 1'b0);
		// A batch of a single sample, then one that ends in the second lane.
		offer_item(CMD_CLASSIFY, 0, 0, zeros, 1'b1);
		offer_item(CMD_CLASSIFY, 0, 0, ones, 1'b0);
		// Bias extremes drive unit 0 into the low clamp and unit 1 into the
		// high clamp; a weight of 255 stores as minus one.
		offer_item(CMD_LOAD_WEIGHT, 0, -128, zeros, 1'b0);
		offer_item(CMD_LOAD_WEIGHT, 1, 127, zeros, 1'b0);
		offer_item(CMD_LOAD_WEIGHT, NH + 1, 127, zeros, 1'b0);
		offer_item(CMD_LOAD_WEIGHT, HID_ENTRIES, 255, zeros, 1'b0);
		offer_item(CMD_LOAD_WEIGHT, ALL_WEIGHTS - 1, -128, zeros, 1'b1);
		offer_item(CMD_CLASSIFY, 0, 0, ones, 1'b1);
		offer_item(CMD_LOAD_TABLE, 255, 255, zeros, 1'b0);
		offer_item(CMD_LOAD_TABLE, 0, -128, zeros, 1'b1);
		offer_item(CMD_LOAD_WEIGHT, HID_ENTRIES + 1, 127, zeros, 1'b0);
		offer_item(CMD_CLASSIFY, 0, 0, zeros, 1'b0);
		offer_item(CMD_CLASSIFY, 0, 0, ones, 1'b0);
		offer_item(CMD_CLASSIFY, 0, 0, stripes, 1'b0);
		offer_item(CMD_CLASSIFY, 0, 0, ones, 1'b0);
		drain_results();

		counted_items = 0;
		for (int p = 0; p < PHASES; p++) begin
			// The first phase runs with no idling at all.
			send_calm = (p == 0);
			recv_calm = (p == 0);
			if (p == 2) begin
				// Back-to-back samples against a receiver that is holding off.
				send_calm = 1'b1;
				hold_requests++;
				repeat (BURST_ITEMS)
					offer_item(CMD_CLASSIFY, 0, 0, random_sample(), $urandom_range(0, 15) == 0);
				send_calm = 1'b0;
			end
			phase_end = (p + 1) * PHASE_ITEMS;
			while (counted_items < phase_end)
				offer_random_item();
			// The sender pauses here until everything has come back.
			drain_results();
		end

		recv_calm = 1'b1;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.outstanding() != 0)
			board.report($sformatf("%0d expected results never arrived", board.outstanding()));
		$display("Covered %0d samples, %0d loads and %0d ignored items under random gaps on both",
			samples_sent, loads_sent, ignored_sent);
		$display("sides and a %0d-cycle output hold; checked %0d words and %0d acknowledges.",
			LONG_HOLD, board.words_checked, board.acks_checked);
		if (board.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results still expected.", board.outstanding());
		$display("FAIL");
		$finish;
	end

endmodule
